>>> design/mlc_pkg.sv
// ----------------------------------------------------------------------------
// Mailbox line classifier package
// Shared constants, character tables, result type and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mlc_pkg;

   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 4;
   localparam int LINE_LEN_W = 10;
   localparam int YEAR_W     = 14;

   localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd90;
   localparam logic [YEAR_W-1:0] YEAR_SAT       = 14'd16383;

   localparam logic [KIND_W-1:0] KIND_BODY     = 4'd0;
   localparam logic [KIND_W-1:0] KIND_START    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FROM     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SUBJECT  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DATE     = 4'd4;
   localparam logic [KIND_W-1:0] KIND_OTHER    = 4'd5;
   localparam logic [KIND_W-1:0] KIND_HDR_END  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_END_OK   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_END_ERR  = 4'd8;

   localparam logic [1:0] YPH_SKIP   = 2'd0;
   localparam logic [1:0] YPH_DIGITS = 2'd1;
   localparam logic [1:0] YPH_DONE   = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

   // "From "
   localparam logic [BYTE_W-1:0] START_WORD [5] = '{8'h46, 8'h72, 8'h6F, 8'h6D, 8'h20};
   // "From: "
   localparam logic [BYTE_W-1:0] HDR_FROM [6] = '{8'h46, 8'h72, 8'h6F, 8'h6D, 8'h3A, 8'h20};
   // "Subject: "
   localparam logic [BYTE_W-1:0] HDR_SUBJ [9] =
      '{8'h53, 8'h75, 8'h62, 8'h6A, 8'h65, 8'h63, 8'h74, 8'h3A, 8'h20};
   // "Date: "
   localparam logic [BYTE_W-1:0] HDR_DATE [6] = '{8'h44, 8'h61, 8'h74, 8'h65, 8'h3A, 8'h20};

   typedef struct packed {
      logic [KIND_W-1:0]     line_kind;
      logic [LINE_LEN_W-1:0] line_length;
      logic                  last;
   } result_type;

   function automatic logic is_dig(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_sp(input logic [BYTE_W-1:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

`default_nettype wire

>>> design/mlc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one stream byte or an end-of-stream marker per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

>>> design/mlc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one classified line or end report per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] line_kind;
   logic [9:0] line_length;
   logic       last;

   modport source (output valid, output line_kind, output line_length, output last,
                   input ready);
   modport sink (input valid, input line_kind, input line_length, input last,
                 output ready);
endinterface

`default_nettype wire

>>> design/mlc_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries a write of the minimum year register per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlc_csr_if;
   logic        valid;
   logic        ready;
   logic [13:0] min_year;

   modport source (output valid, output min_year, input ready);
   modport sink (input valid, input min_year, output ready);
endinterface

`default_nettype wire

>>> design/mlc_result_fifo.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry register queue between the line tracker and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_result_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  mlc_pkg::result_type push_data,
   output logic                room,
   output logic                out_valid,
   input  wire                 out_ready,
   output mlc_pkg::result_type out_data
);

   mlc_pkg::result_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign room      = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/mlc_line_tracker.sv
// ----------------------------------------------------------------------------
// Line tracker
// Per-byte line state update, line boundary detection and classification.
// ----------------------------------------------------------------------------
`default_nettype none

module mlc_line_tracker #(
   parameter int MAX_LINE = 1023
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire [7:0]           data_byte,
   input  wire                 end_of_stream,
   input  wire [13:0]          min_year,
   input  wire                 room,
   output logic                push,
   output mlc_pkg::result_type push_data
);

   localparam int LenW     = $clog2(MAX_LINE + 1);
   localparam int LineLenW = mlc_pkg::LINE_LEN_W;
   localparam int YearW    = mlc_pkg::YEAR_W;

   logic             hdr_ff, hdr_in;
   logic [LenW-1:0]  cnt_ff, cnt_in;
   logic [31:0]      rb_ff, rb_in;
   logic             spo_ff, spo_in;
   logic [2:0]       hpo_ff, hpo_in;
   logic [LenW-1:0]  lnp_ff, lnp_in;
   logic             cpo_ff, cpo_in;
   logic [1:0]       acc_ff, acc_in;
   logic [1:0]       yph_ff, yph_in;
   logic [YearW-1:0] yv_ff, yv_in;
   logic             pend_ff, pend_in;
   logic [3:0]       pend_kind_ff, pend_kind_in;

   logic [LenW-1:0]  tb_cnt, tb_lnp, cls_cnt, cls_lnp;
   logic [31:0]      tb_rb;
   logic             tb_spo, tb_cpo, cls_spo, cls_cpo;
   logic [2:0]       tb_hpo, cls_hpo;
   logic [1:0]       tb_acc, tb_yph, cls_acc;
   logic [YearW-1:0] tb_yv, cls_yv;
   logic [YearW+3:0] yv_prod;
   logic             take_digit, take, boundary, cls_mode;
   logic [3:0]       cls_kind;
   logic [7:0]       b1, b2, b3, b4;

   assign in_ready = room && !pend_ff;
   assign take     = in_valid && in_ready;

   always_comb begin
      b1 = rb_ff[7:0];
      b2 = rb_ff[15:8];
      b3 = rb_ff[23:16];
      b4 = rb_ff[31:24];
      tb_spo = spo_ff;
      if ((cnt_ff < LenW'(5)) && (data_byte != mlc_pkg::START_WORD[cnt_ff[2:0]])) begin
         tb_spo = 1'b0;
      end
      tb_hpo = hpo_ff;
      if ((cnt_ff < LenW'(6)) && (data_byte != mlc_pkg::HDR_FROM[cnt_ff[2:0]])) begin
         tb_hpo[0] = 1'b0;
      end
      if ((cnt_ff < LenW'(9)) && (data_byte != mlc_pkg::HDR_SUBJ[cnt_ff[3:0]])) begin
         tb_hpo[1] = 1'b0;
      end
      if ((cnt_ff < LenW'(6)) && (data_byte != mlc_pkg::HDR_DATE[cnt_ff[2:0]])) begin
         tb_hpo[2] = 1'b0;
      end
      tb_cnt = cnt_ff + LenW'(1);
      tb_lnp = mlc_pkg::is_sp(data_byte) ? lnp_ff : tb_cnt;
      tb_rb  = {rb_ff[23:0], data_byte};
      tb_cpo = cpo_ff;
      tb_acc = acc_ff;
      tb_yph = yph_ff;
      tb_yv  = yv_ff;
      take_digit = 1'b0;
      if (data_byte == mlc_pkg::CHAR_COLON) begin
         tb_cpo = (b3 == mlc_pkg::CHAR_COLON) && mlc_pkg::is_dig(b4) &&
                  mlc_pkg::is_dig(b2) && mlc_pkg::is_dig(b1);
         tb_acc = 2'd0;
         tb_yph = mlc_pkg::YPH_SKIP;
         tb_yv  = '0;
      end else if (acc_ff < 2'd2) begin
         if (!mlc_pkg::is_dig(data_byte)) begin
            tb_cpo = 1'b0;
         end
         tb_acc = acc_ff + 2'd1;
      end else begin
         unique case (yph_ff)
            mlc_pkg::YPH_SKIP: begin
               if (mlc_pkg::is_sp(data_byte)) begin
                  tb_yph = mlc_pkg::YPH_SKIP;
               end else if (data_byte == mlc_pkg::CHAR_PLUS) begin
                  tb_yph = mlc_pkg::YPH_DIGITS;
               end else if (data_byte == mlc_pkg::CHAR_MINUS) begin
                  tb_yv  = '0;
                  tb_yph = mlc_pkg::YPH_DONE;
               end else if (!mlc_pkg::is_dig(data_byte)) begin
                  tb_yph = mlc_pkg::YPH_DONE;
               end else begin
                  tb_yph     = mlc_pkg::YPH_DIGITS;
                  take_digit = 1'b1;
               end
            end
            mlc_pkg::YPH_DIGITS: begin
               if (mlc_pkg::is_dig(data_byte)) begin
                  take_digit = 1'b1;
               end else begin
                  tb_yph = mlc_pkg::YPH_DONE;
               end
            end
            default: begin
               tb_yph = yph_ff;
            end
         endcase
      end
      yv_prod = ({4'b0, yv_ff} << 3) + ({4'b0, yv_ff} << 1) +
                (YearW + 4)'(data_byte - mlc_pkg::CHAR_ZERO);
      if (take_digit) begin
         tb_yv = (yv_prod[YearW+3:YearW] != 4'd0) ? mlc_pkg::YEAR_SAT : yv_prod[YearW-1:0];
      end
   end

   always_comb begin
      cls_spo = end_of_stream ? spo_ff : tb_spo;
      cls_cnt = end_of_stream ? cnt_ff : tb_cnt;
      cls_cpo = end_of_stream ? cpo_ff : tb_cpo;
      cls_acc = end_of_stream ? acc_ff : tb_acc;
      cls_yv  = end_of_stream ? yv_ff : tb_yv;
      cls_lnp = end_of_stream ? lnp_ff : tb_lnp;
      cls_hpo = end_of_stream ? hpo_ff : tb_hpo;
      if (!hdr_ff) begin
         if (cls_spo && (cls_cnt >= LenW'(5)) && cls_cpo && (cls_acc >= 2'd2) &&
             (cls_yv > min_year)) begin
            cls_mode = 1'b1;
            cls_kind = mlc_pkg::KIND_START;
         end else begin
            cls_mode = 1'b0;
            cls_kind = mlc_pkg::KIND_BODY;
         end
      end else if (cls_lnp == '0) begin
         cls_mode = 1'b0;
         cls_kind = mlc_pkg::KIND_HDR_END;
      end else begin
         cls_mode = 1'b1;
         if (cls_hpo[0] && (cls_lnp > LenW'(6))) begin
            cls_kind = mlc_pkg::KIND_FROM;
         end else if (cls_hpo[1] && (cls_lnp > LenW'(9))) begin
            cls_kind = mlc_pkg::KIND_SUBJECT;
         end else if (cls_hpo[2] && (cls_lnp > LenW'(6))) begin
            cls_kind = mlc_pkg::KIND_DATE;
         end else begin
            cls_kind = mlc_pkg::KIND_OTHER;
         end
      end
   end

   always_comb begin
      boundary     = (data_byte == mlc_pkg::CHAR_LF) || (tb_cnt >= LenW'(MAX_LINE));
      hdr_in       = hdr_ff;
      cnt_in       = cnt_ff;
      rb_in        = rb_ff;
      spo_in       = spo_ff;
      hpo_in       = hpo_ff;
      lnp_in       = lnp_ff;
      cpo_in       = cpo_ff;
      acc_in       = acc_ff;
      yph_in       = yph_ff;
      yv_in        = yv_ff;
      pend_in      = pend_ff;
      pend_kind_in = pend_kind_ff;
      push         = 1'b0;
      push_data    = '{line_kind: cls_kind, line_length: LineLenW'(cls_cnt), last: 1'b1};
      if (pend_ff) begin
         push_data = '{line_kind: pend_kind_ff, line_length: '0, last: 1'b1};
         if (room) begin
            push    = 1'b1;
            pend_in = 1'b0;
         end
      end else if (take) begin
         push = 1'b1;
         if (end_of_stream || boundary) begin
            cnt_in = '0;
            rb_in  = '0;
            spo_in = 1'b1;
            hpo_in = 3'b111;
            lnp_in = '0;
            cpo_in = 1'b0;
            acc_in = 2'd0;
            yph_in = mlc_pkg::YPH_SKIP;
            yv_in  = '0;
         end
         if (end_of_stream) begin
            hdr_in = 1'b0;
            if (cnt_ff != '0) begin
               push_data.last = 1'b0;
               pend_in        = 1'b1;
               pend_kind_in   = cls_mode ? mlc_pkg::KIND_END_ERR : mlc_pkg::KIND_END_OK;
            end else begin
               push_data = '{line_kind: hdr_ff ? mlc_pkg::KIND_END_ERR : mlc_pkg::KIND_END_OK,
                             line_length: '0, last: 1'b1};
            end
         end else if (boundary) begin
            hdr_in = cls_mode;
         end else begin
            push   = 1'b0;
            cnt_in = tb_cnt;
            rb_in  = tb_rb;
            spo_in = tb_spo;
            hpo_in = tb_hpo;
            lnp_in = tb_lnp;
            cpo_in = tb_cpo;
            acc_in = tb_acc;
            yph_in = tb_yph;
            yv_in  = tb_yv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= 1'b0;
         cnt_ff  <= '0;
         rb_ff   <= '0;
         spo_ff  <= 1'b1;
         hpo_ff  <= 3'b111;
         lnp_ff  <= '0;
         cpo_ff  <= 1'b0;
         acc_ff  <= 2'd0;
         yph_ff  <= mlc_pkg::YPH_SKIP;
         yv_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         hdr_ff  <= hdr_in;
         cnt_ff  <= cnt_in;
         rb_ff   <= rb_in;
         spo_ff  <= spo_in;
         hpo_ff  <= hpo_in;
         lnp_ff  <= lnp_in;
         cpo_ff  <= cpo_in;
         acc_ff  <= acc_in;
         yph_ff  <= yph_in;
         yv_ff   <= yv_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
   end

`ifndef SYNTH
   a_pend_blocks_input: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !in_ready) else $error("input accepted while end report pending");

   a_partial_line_end: assert property (@(posedge clock) disable iff (reset)
      (take && end_of_stream && (cnt_ff != '0)) |=> pend_ff)
      else $error("end report not queued after partial line");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < LenW'(MAX_LINE)) else $error("line count reached limit without split");

   a_nonspace_bound: assert property (@(posedge clock) disable iff (reset)
      lnp_ff <= cnt_ff) else $error("nonspace position beyond line count");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> room) else $error("result pushed into full buffer");
`endif

endmodule

`default_nettype wire

>>> design/mbox_line_classifier_unit.sv
// ----------------------------------------------------------------------------
// Mailbox line classifier
// Splits an mbox byte stream into lines and reports a class for each line.
// ----------------------------------------------------------------------------
// The request channel takes one byte per transaction, or an end-of-stream
// marker whose byte is ignored. Every newline, and every MAX_LINE bytes
// without one, closes a line and yields one response with its class and
// length. An end-of-stream transaction yields the end report, preceded by the
// class of any unfinished line; the last flag marks the final response of a
// request. The csr channel writes min_year and is always ready; write it only
// while no request is in flight.
// One byte is accepted per cycle while the buffer has room and no end
// report is pending. A response is pushed into the result buffer when the
// request that caused it is accepted. An end of stream that closes a partial
// line holds off the request channel while its second response is queued.
// Responses go through a two-entry buffer; when the receiver stalls and the
// buffer fills, request ready drops until an entry is taken.
// Reset returns the block to body mode with an empty line and buffer, and
// sets min_year to 90.
// ----------------------------------------------------------------------------
`default_nettype none

module mbox_line_classifier_unit #(
   parameter int MAX_LINE = 1023
) (
   input  wire       clock,
   input  wire       reset,
   mlc_req_if.sink   req_ch,
   mlc_rsp_if.source rsp_ch,
   mlc_csr_if.sink   csr_ch
);

   logic [13:0]         min_year_ff, min_year_in;
   logic                room;
   logic                push;
   mlc_pkg::result_type push_data;
   mlc_pkg::result_type out_data;

   assign csr_ch.ready = 1'b1;
   assign min_year_in  = (csr_ch.valid && csr_ch.ready) ? csr_ch.min_year : min_year_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= mlc_pkg::MIN_YEAR_RESET;
      end else begin
         min_year_ff <= min_year_in;
      end
   end

   mlc_line_tracker #(
      .MAX_LINE (MAX_LINE)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_ch.valid),
      .in_ready      (req_ch.ready),
      .data_byte     (req_ch.data_byte),
      .end_of_stream (req_ch.end_of_stream),
      .min_year      (min_year_ff),
      .room          (room),
      .push          (push),
      .push_data     (push_data)
   );

   mlc_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.line_kind   = out_data.line_kind;
   assign rsp_ch.line_length = out_data.line_length;
   assign rsp_ch.last        = out_data.last;

endmodule

`default_nettype wire
